// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_DEB_FIRST   = 3'd1,
        ST_WAIT_REL1   = 3'd2,
        ST_WAIT_PRESS2 = 3'd3,
        ST_DEB_SECOND  = 3'd4,
        ST_WAIT_REL2   = 3'd5
    } bcc_state_t;

    localparam logic [TYPE_W-1:0] TYPE_NONE   = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_SINGLE = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_DOUBLE = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_LONG   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 2'd2;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [LIMIT_W-1:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [LIMIT_W-1:0] DOUBLE_GAP_RESET = 16'd300;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } bcc_item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce_ms;
        logic [LIMIT_W-1:0] long_press_ms;
        logic [LIMIT_W-1:0] double_gap_ms;
    } bcc_cfg_t;

    // (now - start) mod 2^32 >= limit
    function automatic logic elapsed_at_least(
        input logic [TIME_W-1:0]  now,
        input logic [TIME_W-1:0]  start,
        input logic [LIMIT_W-1:0] limit
    );
        logic [TIME_W-1:0] diff;
        begin
            diff = now - start;
            return diff >= {{(TIME_W-LIMIT_W){1'b0}}, limit};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bcc_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bcc_sample_if;
    logic                      valid;
    logic                      ready;
    logic                      pin_level;
    logic [bcc_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output pin_level, output now_ms, input ready);
    modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcc_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bcc_result_if;
    logic                      valid;
    logic                      ready;
    logic [bcc_pkg::TYPE_W-1:0] press_type;

    modport source (output valid, output press_type, input ready);
    modport sink (input valid, input press_type, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcc_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bcc_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bcc_pkg::CFG_IDX_W-1:0] index;
    logic [bcc_pkg::LIMIT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bcc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_cfg_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bcc_cfg_if.sink          cfg,
    output bcc_pkg::bcc_cfg_t regs
);

    bcc_pkg::bcc_cfg_t regs_reg;
    bcc_pkg::bcc_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                bcc_pkg::REG_DEBOUNCE:   regs_next.debounce_ms   = cfg.data;
                bcc_pkg::REG_LONG_PRESS: regs_next.long_press_ms = cfg.data;
                bcc_pkg::REG_DOUBLE_GAP: regs_next.double_gap_ms = cfg.data;
                default:                 regs_next               = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.debounce_ms   <= bcc_pkg::DEBOUNCE_RESET;
            regs_reg.long_press_ms <= bcc_pkg::LONG_PRESS_RESET;
            regs_reg.double_gap_ms <= bcc_pkg::DOUBLE_GAP_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bcc_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    bcc_sample_if.sink         sample,
    input  wire logic          take,
    output logic               item_valid,
    output bcc_pkg::bcc_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    bcc_pkg::bcc_item_t item_reg;
    logic               load;

    // slot frees up in the same cycle the fsm takes the held beat
    assign sample.ready = !valid_reg || take;
    assign load         = sample.valid && sample.ready;
    assign item_valid   = valid_reg;
    assign item         = item_reg;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.pin_level <= sample.pin_level;
            item_reg.now_ms    <= sample.now_ms;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bcc_fsm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_fsm (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire bcc_pkg::bcc_item_t item,
    input  wire bcc_pkg::bcc_cfg_t  regs,
    output logic                    take,
    bcc_result_if.source            result
);

    bcc_pkg::bcc_state_t         state_reg;
    bcc_pkg::bcc_state_t         state_next;
    logic [bcc_pkg::TIME_W-1:0]  press_start_reg;
    logic [bcc_pkg::TIME_W-1:0]  press_start_next;
    logic [bcc_pkg::TIME_W-1:0]  release_start_reg;
    logic [bcc_pkg::TIME_W-1:0]  release_start_next;
    logic [bcc_pkg::TYPE_W-1:0]  type_reg;
    logic [bcc_pkg::TYPE_W-1:0]  type_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        deb_done;
    logic                        long_done;
    logic                        gap_done;

    // one step per beat; the reported type doubles as the result payload
    assign take              = item_valid && (!out_valid_reg || result.ready);
    assign result.valid      = out_valid_reg;
    assign result.press_type = type_reg;

    assign deb_done  = bcc_pkg::elapsed_at_least(item.now_ms, press_start_reg,
                                                 regs.debounce_ms);
    assign long_done = bcc_pkg::elapsed_at_least(item.now_ms, press_start_reg,
                                                 regs.long_press_ms);
    assign gap_done  = bcc_pkg::elapsed_at_least(item.now_ms, release_start_reg,
                                                 regs.double_gap_ms);

    always_comb
    begin
        state_next         = state_reg;
        press_start_next   = press_start_reg;
        release_start_next = release_start_reg;
        type_next          = type_reg;
        unique case (state_reg)
            bcc_pkg::ST_IDLE:
            begin
                type_next = bcc_pkg::TYPE_NONE;
                if (item.pin_level)
                begin
                    state_next       = bcc_pkg::ST_DEB_FIRST;
                    press_start_next = item.now_ms;
                end
            end
            bcc_pkg::ST_DEB_FIRST:
            begin
                if (deb_done)
                begin
                    if (item.pin_level)
                        state_next = bcc_pkg::ST_WAIT_REL1;
                    else
                    begin
                        // press lost while settling: gap timer starts now
                        release_start_next = item.now_ms;
                        state_next         = bcc_pkg::ST_WAIT_PRESS2;
                    end
                end
            end
            bcc_pkg::ST_WAIT_REL1:
            begin
                if (!item.pin_level)
                begin
                    if (long_done)
                    begin
                        type_next  = bcc_pkg::TYPE_LONG;
                        state_next = bcc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        release_start_next = item.now_ms;
                        state_next         = bcc_pkg::ST_WAIT_PRESS2;
                    end
                end
            end
            bcc_pkg::ST_WAIT_PRESS2:
            begin
                // gap expiry wins over a press in the same beat
                if (gap_done)
                begin
                    type_next  = bcc_pkg::TYPE_SINGLE;
                    state_next = bcc_pkg::ST_IDLE;
                end
                else if (item.pin_level)
                begin
                    state_next       = bcc_pkg::ST_DEB_SECOND;
                    press_start_next = item.now_ms;
                end
            end
            bcc_pkg::ST_DEB_SECOND:
            begin
                if (deb_done)
                begin
                    if (item.pin_level)
                        state_next = bcc_pkg::ST_WAIT_REL2;
                    else
                    begin
                        type_next  = bcc_pkg::TYPE_SINGLE;
                        state_next = bcc_pkg::ST_IDLE;
                    end
                end
            end
            bcc_pkg::ST_WAIT_REL2:
            begin
                if (!item.pin_level)
                begin
                    type_next  = bcc_pkg::TYPE_DOUBLE;
                    state_next = bcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (take)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= bcc_pkg::ST_IDLE;
            press_start_reg   <= '0;
            release_start_reg <= '0;
            type_reg          <= bcc_pkg::TYPE_NONE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                state_reg         <= state_next;
                press_start_reg   <= press_start_next;
                release_start_reg <= release_start_next;
                type_reg          <= type_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/button_click_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Classifies button presses from a stream of (pin_level, now_ms) samples into none,
// single, double or long clicks, one result beat per sample beat. Throughput is
// one sample per clock while the output is not stalled. The rate is set by the
// state update loop, which does the three 32-bit elapsed-time subtract-and-compares
// and the next-state choice combinationally. A sample register and a result
// register sit on either side of that loop, so while a finished result waits the
// input takes one more sample and then holds ready low. Threshold registers are
// written through cfg (index 0 debounce, 1 long press, 2 double gap; others ignored)
// and must only be changed while no sample is in flight.
module button_click_classifier (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bcc_sample_if.sink   sample,
    bcc_result_if.source result,
    bcc_cfg_if.sink      cfg
);

    bcc_pkg::bcc_cfg_t  regs;
    bcc_pkg::bcc_item_t item;
    logic               item_valid;
    logic               take;

    bcc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    bcc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    bcc_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .regs       (regs),
        .take       (take),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== rtl/bcc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bcc_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       sample_valid,
    input wire logic                       sample_ready,
    input wire logic                       result_valid,
    input wire logic                       result_ready,
    input wire logic [bcc_pkg::TYPE_W-1:0] press_type
);

    logic result_beat;
    logic click_beat;

    assign result_beat = result_valid && result_ready;
    assign click_beat  = result_beat && (press_type != bcc_pkg::TYPE_NONE);

    `BCC_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid)
    `BCC_ASSERT_NEXT(a_type_holds, result_valid && !result_ready, $stable(press_type))
    // a draining output never backs up the sample side
    `BCC_ASSERT_NOW(a_ready_follows, result_ready, sample_ready)
    // a reported click is always followed by an idle step that clears it
    `BCC_ASSERT_NEXT(a_click_clears, click_beat, !click_beat)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .press_type   (result.press_type)
);

`default_nettype wire
